@@ hw/rtl/cssf_pkg.sv @@
// ----------------------------------------------------------------------------
// cssf_pkg
// Shared types and constants of the cross-shift sharpening filter.
// ----------------------------------------------------------------------------
package cssf_pkg;

    localparam int PIX_W      = 8;
    localparam int NUM_W      = 19;
    localparam int DEN_W      = 10;
    localparam int QUOT_W     = 8;
    localparam int MAG_W      = DEN_W + QUOT_W;
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_GAIN   = 2'd2;
    localparam logic [1:0] REG_SHIFT  = 2'd3;

    localparam logic [11:0] WIDTH_RESET  = 12'd2048;
    localparam logic [15:0] HEIGHT_RESET = 16'd480;
    localparam logic [7:0]  GAIN_RESET   = 8'd128;
    localparam logic [2:0]  SHIFT_RESET  = 3'd2;

    typedef struct packed {
        logic             opcode;
        logic [PIX_W-1:0] pixel_in;
    } in_word_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_out;
        logic             clamped;
        logic             end_of_frame;
    } out_word_t;

    typedef struct packed {
        logic valid;
        logic eof;
    } div_ctl_t;

endpackage

@@ hw/rtl/cssf_linebuf.sv @@
// ----------------------------------------------------------------------------
// cssf_linebuf
// Row-slot line store: one bank per row slot, one write port and two
// registered read ports per bank.
// ----------------------------------------------------------------------------
module cssf_linebuf #(
    parameter int MAX_WIDTH = 2048,
    parameter int SLOTS     = 8
) (
    input  logic                                  clk,
    input  logic                                  en,
    input  logic                                  wr_en,
    input  logic [$clog2(SLOTS)-1:0]              wr_slot,
    input  logic [$clog2(MAX_WIDTH)-1:0]          wr_col,
    input  logic [cssf_pkg::PIX_W-1:0]            wr_data,
    input  logic [$clog2(MAX_WIDTH)-1:0]          rd_col_a,
    input  logic [$clog2(MAX_WIDTH)-1:0]          rd_col_b,
    output logic [SLOTS-1:0][cssf_pkg::PIX_W-1:0] rd_a,
    output logic [SLOTS-1:0][cssf_pkg::PIX_W-1:0] rd_b
);

    localparam int SLOT_W = $clog2(SLOTS);

    for (genvar i = 0; i < SLOTS; i++) begin : g_bank
        logic [cssf_pkg::PIX_W-1:0] mem [MAX_WIDTH];

        always_ff @(posedge clk)
        begin
            if (wr_en && (wr_slot == SLOT_W'(i)))
            begin
                mem[wr_col] <= wr_data;
            end
            if (en)
            begin
                rd_a[i] <= mem[rd_col_a];
                rd_b[i] <= mem[rd_col_b];
            end
        end
    end

endmodule

@@ hw/rtl/cssf_div.sv @@
// ----------------------------------------------------------------------------
// cssf_div
// Pipelined restoring divider, one quotient bit per stage, with truncation
// toward zero and saturation of the quotient to 0..255.
// ----------------------------------------------------------------------------
module cssf_div (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     en,
    input  cssf_pkg::div_ctl_t                       ctl_in,
    input  logic signed [cssf_pkg::NUM_W-1:0]        num,
    input  logic [cssf_pkg::DEN_W-1:0]               den,
    output cssf_pkg::div_ctl_t                       ctl_out,
    output logic [cssf_pkg::QUOT_W-1:0]              quot,
    output logic                                     clamped
);

    localparam int STEPS = cssf_pkg::QUOT_W;
    localparam int MAG_W = cssf_pkg::MAG_W;

    cssf_pkg::div_ctl_t ctl_reg [STEPS+1];
    logic [MAG_W-1:0]   rem_reg [STEPS+1];
    logic [STEPS-1:0]   q_reg   [STEPS+1];
    logic               hi_reg  [STEPS+1];
    logic               zero_reg[STEPS+1];
    logic               clamp_reg[STEPS+1];

    logic               neg;
    logic [MAG_W-1:0]   mag;
    logic               over;
    logic               under;

    always_comb
    begin
        neg   = num[cssf_pkg::NUM_W-1];
        mag   = neg ? MAG_W'(-num) : MAG_W'(num);
        over  = !neg && (mag >= MAG_W'({den, {STEPS{1'b0}}}));
        under = neg && (mag >= MAG_W'(den));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg[0] <= '0;
        end
        else if (en)
        begin
            ctl_reg[0] <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]   <= mag;
            q_reg[0]     <= '0;
            hi_reg[0]    <= over;
            zero_reg[0]  <= neg;
            clamp_reg[0] <= over || under;
        end
    end

    for (genvar s = 1; s <= STEPS; s++) begin : g_step
        logic [MAG_W-1:0] trial;
        logic             fits;

        always_comb
        begin
            trial = MAG_W'(den) << (STEPS - s);
            fits  = rem_reg[s-1] >= trial;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ctl_reg[s] <= '0;
            end
            else if (en)
            begin
                ctl_reg[s] <= ctl_reg[s-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s]   <= fits ? (rem_reg[s-1] - trial) : rem_reg[s-1];
                q_reg[s]     <= q_reg[s-1] | (fits ? (STEPS'(1) << (STEPS - s)) : '0);
                hi_reg[s]    <= hi_reg[s-1];
                zero_reg[s]  <= zero_reg[s-1];
                clamp_reg[s] <= clamp_reg[s-1];
            end
        end
    end

    assign ctl_out = ctl_reg[STEPS];
    assign clamped = clamp_reg[STEPS];
    assign quot    = hi_reg[STEPS] ? '1 : (zero_reg[STEPS] ? '0 : q_reg[STEPS]);

endmodule

@@ hw/rtl/cross_shift_sharpen_filter.sv @@
// ----------------------------------------------------------------------------
// cross_shift_sharpen_filter
// Cross-shift sharpening of a raster pixel stream, one color channel.
// ----------------------------------------------------------------------------
//  Channel   Signals                          Word
//  feed      feed_valid / feed_ready          in_word_t: opcode, pixel_in
//  result    result_valid / result_ready      out_word_t: pixel_out, clamped,
//                                             end_of_frame
//  config    psel penable pwrite paddr        four registers at 0, 4, 8, 12
//            pwdata prdata pready
//
// One word is accepted per clock while the result channel does not stall;
// each result passes four filter stages and the 9-stage divider.
// Results trail the input by shift_distance rows; flush words drain the end.
// Reset clears counters and valid bits; the line store holds no reset state.
// A stalled result stops the whole pipeline; feed_ready drops in that cycle.
// ----------------------------------------------------------------------------
module cross_shift_sharpen_filter #(
    parameter int MAX_WIDTH = 2048,
    parameter int MAX_SHIFT = 4
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                feed_valid,
    output logic                                feed_ready,
    input  cssf_pkg::in_word_t                  feed_word,
    output logic                                result_valid,
    input  logic                                result_ready,
    output cssf_pkg::out_word_t                 result_word,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [cssf_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [cssf_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [cssf_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);

    localparam int SLOTS  = 2 * MAX_SHIFT;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int WCNT_W = $clog2(MAX_WIDTH + 1);
    localparam int CV_W   = $clog2(MAX_WIDTH + MAX_SHIFT + 1);
    localparam int VW     = $clog2(MAX_SHIFT + 1);
    localparam int PIX_W  = cssf_pkg::PIX_W;

    logic [11:0] width_reg;
    logic [15:0] height_reg;
    logic [7:0]  gain_reg;
    logic [2:0]  shift_reg;

    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= cssf_pkg::WIDTH_RESET;
            height_reg <= cssf_pkg::HEIGHT_RESET;
            gain_reg   <= cssf_pkg::GAIN_RESET;
            shift_reg  <= cssf_pkg::SHIFT_RESET;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                cssf_pkg::REG_WIDTH:  width_reg  <= pwdata[11:0];
                cssf_pkg::REG_HEIGHT: height_reg <= pwdata[15:0];
                cssf_pkg::REG_GAIN:   gain_reg   <= pwdata[7:0];
                cssf_pkg::REG_SHIFT:  shift_reg  <= pwdata[2:0];
                default:              width_reg  <= width_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            cssf_pkg::REG_WIDTH:  prdata = {20'd0, width_reg};
            cssf_pkg::REG_HEIGHT: prdata = {16'd0, height_reg};
            cssf_pkg::REG_GAIN:   prdata = {24'd0, gain_reg};
            cssf_pkg::REG_SHIFT:  prdata = {29'd0, shift_reg};
            default:              prdata = '0;
        endcase
    end

    logic [WCNT_W-1:0] w_eff;
    logic [15:0]       h_eff;
    logic [VW-1:0]     v_eff;

    always_comb
    begin
        if (width_reg == '0)
            w_eff = WCNT_W'(1);
        else if (32'(width_reg) > MAX_WIDTH)
            w_eff = WCNT_W'(MAX_WIDTH);
        else
            w_eff = WCNT_W'(width_reg);

        h_eff = (height_reg == '0) ? 16'd1 : height_reg;

        if (shift_reg == '0)
            v_eff = VW'(1);
        else if (32'(shift_reg) > MAX_SHIFT)
            v_eff = VW'(MAX_SHIFT);
        else
            v_eff = VW'(shift_reg);
    end

    logic              en;
    logic              accept;

    logic [15:0]       in_row_reg,  in_row_next;
    logic [COL_W-1:0]  in_col_reg,  in_col_next;
    logic [SLOT_W-1:0] in_slot_reg, in_slot_next;
    logic [15:0]       out_row_reg, out_row_next;
    logic [COL_W-1:0]  out_col_reg, out_col_next;
    logic [SLOT_W-1:0] out_slot_reg, out_slot_next;

    logic              restart;
    logic [15:0]       ir, orow;
    logic [COL_W-1:0]  ic, oc;
    logic [SLOT_W-1:0] islot, oslot;
    logic              in_done;
    logic              out_busy;
    logic              is_pix;
    logic              emit;
    logic              wr_pix;
    logic [CV_W-1:0]   ic_inc, oc_inc, oc_plus_v;
    logic [15:0]       out_row_adv;
    logic [COL_W-1:0]  out_col_adv;
    logic [SLOT_W-1:0] out_slot_adv;
    logic [15:0]       in_row_adv;
    logic [COL_W-1:0]  in_col_adv;
    logic [SLOT_W-1:0] in_slot_adv;
    logic              vval, hval, eof;
    logic [SLOT_W:0]   tslot_sum, bslot_sum;
    logic [SLOT_W-1:0] tslot, bslot;
    logic [COL_W-1:0]  rd_col_b;

    always_comb
    begin
        restart  = (in_row_reg >= h_eff) && (out_row_reg >= h_eff);
        ir       = restart ? '0 : in_row_reg;
        ic       = restart ? '0 : in_col_reg;
        islot    = restart ? '0 : in_slot_reg;
        orow     = restart ? '0 : out_row_reg;
        oc       = restart ? '0 : out_col_reg;
        oslot    = restart ? '0 : out_slot_reg;

        in_done  = ir >= h_eff;
        out_busy = orow < h_eff;
        is_pix   = feed_word.opcode == cssf_pkg::OP_PIXEL;
        wr_pix   = !in_done && is_pix;
        if (in_done)
            emit = out_busy;
        else
            emit = is_pix && out_busy && (17'(orow) + 17'(v_eff) == 17'(ir)) && (oc == ic);

        ic_inc = CV_W'(ic) + CV_W'(1);
        if (ic_inc >= CV_W'(w_eff))
        begin
            in_col_adv  = '0;
            in_row_adv  = ir + 16'd1;
            in_slot_adv = (32'(islot) == SLOTS - 1) ? '0 : islot + SLOT_W'(1);
        end
        else
        begin
            in_col_adv  = COL_W'(ic_inc);
            in_row_adv  = ir;
            in_slot_adv = islot;
        end

        oc_inc = CV_W'(oc) + CV_W'(1);
        if (oc_inc >= CV_W'(w_eff))
        begin
            out_col_adv  = '0;
            out_row_adv  = orow + 16'd1;
            out_slot_adv = (32'(oslot) == SLOTS - 1) ? '0 : oslot + SLOT_W'(1);
        end
        else
        begin
            out_col_adv  = COL_W'(oc_inc);
            out_row_adv  = orow;
            out_slot_adv = oslot;
        end

        eof       = out_row_adv >= h_eff;
        vval      = (orow >= 16'(v_eff)) && (17'(orow) + 17'(v_eff) < 17'(h_eff));
        oc_plus_v = CV_W'(oc) + CV_W'(v_eff);
        hval      = (CV_W'(oc) >= CV_W'(v_eff)) && (oc_plus_v < CV_W'(w_eff));
        rd_col_b  = (oc_plus_v < CV_W'(MAX_WIDTH)) ? COL_W'(oc_plus_v) : oc;

        tslot_sum = (SLOT_W+1)'(oslot) + (SLOT_W+1)'(SLOTS) - (SLOT_W+1)'(v_eff);
        if (32'(tslot_sum) >= SLOTS)
            tslot_sum = tslot_sum - (SLOT_W+1)'(SLOTS);
        tslot = SLOT_W'(tslot_sum);
        bslot_sum = (SLOT_W+1)'(oslot) + (SLOT_W+1)'(v_eff);
        if (32'(bslot_sum) >= SLOTS)
            bslot_sum = bslot_sum - (SLOT_W+1)'(SLOTS);
        bslot = SLOT_W'(bslot_sum);

        in_row_next   = in_row_reg;
        in_col_next   = in_col_reg;
        in_slot_next  = in_slot_reg;
        out_row_next  = out_row_reg;
        out_col_next  = out_col_reg;
        out_slot_next = out_slot_reg;
        if (accept)
        begin
            in_row_next   = wr_pix ? in_row_adv  : ir;
            in_col_next   = wr_pix ? in_col_adv  : ic;
            in_slot_next  = wr_pix ? in_slot_adv : islot;
            out_row_next  = emit ? out_row_adv  : orow;
            out_col_next  = emit ? out_col_adv  : oc;
            out_slot_next = emit ? out_slot_adv : oslot;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_row_reg   <= '0;
            in_col_reg   <= '0;
            in_slot_reg  <= '0;
            out_row_reg  <= '0;
            out_col_reg  <= '0;
            out_slot_reg <= '0;
        end
        else
        begin
            in_row_reg   <= in_row_next;
            in_col_reg   <= in_col_next;
            in_slot_reg  <= in_slot_next;
            out_row_reg  <= out_row_next;
            out_col_reg  <= out_col_next;
            out_slot_reg <= out_slot_next;
        end
    end

    logic [SLOTS-1:0][PIX_W-1:0] rd_a;
    logic [SLOTS-1:0][PIX_W-1:0] rd_b;

    cssf_linebuf #(
        .MAX_WIDTH (MAX_WIDTH),
        .SLOTS     (SLOTS)
    ) u_linebuf (
        .clk      (clk),
        .en       (en),
        .wr_en    (accept && wr_pix),
        .wr_slot  (islot),
        .wr_col   (ic),
        .wr_data  (feed_word.pixel_in),
        .rd_col_a (oc),
        .rd_col_b (rd_col_b),
        .rd_a     (rd_a),
        .rd_b     (rd_b)
    );

    logic              v1_reg;
    logic              flush1_reg, vval1_reg, hval1_reg, eof1_reg;
    logic [PIX_W-1:0]  pix1_reg;
    logic [SLOT_W-1:0] cslot1_reg, tslot1_reg, bslot1_reg;

    logic              v2_reg;
    logic [PIX_W-1:0]  p2_reg, right2_reg;
    logic [PIX_W:0]    vs2_reg;
    logic              hval2_reg, eof2_reg;

    logic              v3_reg;
    logic [PIX_W-1:0]  p3_reg;
    logic [PIX_W:0]    half3_reg;
    logic              eof3_reg;

    logic                                 v4_reg;
    logic signed [cssf_pkg::NUM_W-1:0]    num4_reg;
    logic                                 eof4_reg;

    logic [PIX_W-1:0]  hist_reg [MAX_SHIFT];

    logic [PIX_W-1:0]  center1, top1, bot_store1, right1, bottom1;
    logic [PIX_W:0]    vs1;
    logic [PIX_W-1:0]  left2;
    logic [PIX_W:0]    hs2;
    logic [PIX_W+1:0]  sum2;
    logic [PIX_W+8:0]  prod3;
    logic signed [cssf_pkg::NUM_W-1:0] num3;
    logic [cssf_pkg::DEN_W-1:0]        den;

    cssf_pkg::div_ctl_t div_in, div_out;
    logic [PIX_W-1:0]   quot;
    logic               clamped;

    assign accept     = feed_valid && en;
    assign en         = !result_valid || result_ready;
    assign feed_ready = en;

    always_comb
    begin
        center1    = '0;
        right1     = '0;
        top1       = '0;
        bot_store1 = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (cslot1_reg == SLOT_W'(i))
            begin
                center1 = rd_a[i];
                right1  = rd_b[i];
            end
            if (tslot1_reg == SLOT_W'(i))
                top1 = rd_a[i];
            if (bslot1_reg == SLOT_W'(i))
                bot_store1 = rd_a[i];
        end
        bottom1 = flush1_reg ? bot_store1 : pix1_reg;
        vs1     = vval1_reg ? ((PIX_W+1)'(top1) + (PIX_W+1)'(bottom1)) : '0;

        left2 = '0;
        for (int i = 0; i < MAX_SHIFT; i++)
        begin
            if (32'(v_eff) == i + 1)
                left2 = hist_reg[i];
        end
        hs2  = hval2_reg ? ((PIX_W+1)'(left2) + (PIX_W+1)'(right2_reg)) : '0;
        sum2 = (PIX_W+2)'(vs2_reg) + (PIX_W+2)'(hs2);

        prod3 = gain_reg * half3_reg;
        num3  = $signed({2'b00, p3_reg, 9'd0}) - $signed({2'b00, prod3});

        den = 10'd512 - {1'b0, gain_reg, 1'b0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= accept && emit;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            flush1_reg <= in_done;
            vval1_reg  <= vval;
            hval1_reg  <= hval;
            eof1_reg   <= eof;
            pix1_reg   <= feed_word.pixel_in;
            cslot1_reg <= oslot;
            tslot1_reg <= tslot;
            bslot1_reg <= bslot;

            p2_reg     <= center1;
            right2_reg <= right1;
            vs2_reg    <= vs1;
            hval2_reg  <= hval1_reg;
            eof2_reg   <= eof1_reg;

            p3_reg     <= p2_reg;
            half3_reg  <= sum2[PIX_W+1:1];
            eof3_reg   <= eof2_reg;

            num4_reg   <= num3;
            eof4_reg   <= eof3_reg;
        end
        if (en && v2_reg)
        begin
            hist_reg[0] <= p2_reg;
            for (int i = 1; i < MAX_SHIFT; i++)
                hist_reg[i] <= hist_reg[i-1];
        end
    end

    assign div_in.valid = v4_reg;
    assign div_in.eof   = eof4_reg;

    cssf_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .ctl_in  (div_in),
        .num     (num4_reg),
        .den     (den),
        .ctl_out (div_out),
        .quot    (quot),
        .clamped (clamped)
    );

    assign result_valid             = div_out.valid;
    assign result_word.pixel_out    = quot;
    assign result_word.clamped      = clamped;
    assign result_word.end_of_frame = div_out.eof;

endmodule

@@ hw/rtl/cssf_checker.sv @@
// ----------------------------------------------------------------------------
// cssf_checker
// Port-level checks of the sharpening filter, bound to its top level.
// ----------------------------------------------------------------------------
module cssf_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                feed_valid,
    input logic                                feed_ready,
    input cssf_pkg::in_word_t                  feed_word,
    input logic                                result_valid,
    input logic                                result_ready,
    input cssf_pkg::out_word_t                 result_word,
    input logic                                psel,
    input logic                                penable,
    input logic                                pwrite,
    input logic [cssf_pkg::APB_ADDR_W-1:0]     paddr,
    input logic [cssf_pkg::APB_DATA_W-1:0]     pwdata,
    input logic [cssf_pkg::APB_DATA_W-1:0]     prdata,
    input logic                                pready
);

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result_word))
        else $error("Stalled result word changed or vanished.");

    a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !feed_ready |-> result_valid && !result_ready)
        else $error("Input was refused without an output stall.");

    a_clamp_limits: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_word.clamped |->
            (result_word.pixel_out == 8'd0 || result_word.pixel_out == 8'd255))
        else $error("Clamped word is not at a saturation limit.");

    a_gain_readback: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && pready && paddr[3:2] == cssf_pkg::REG_GAIN)
        ##1 (psel && !pwrite && paddr[3:2] == cssf_pkg::REG_GAIN)
        |-> prdata == {24'd0, $past(pwdata[7:0])})
        else $error("Gain register read back a wrong value.");

endmodule

bind cross_shift_sharpen_filter cssf_checker u_cssf_checker (.*);

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the cross-shift sharpening filter. Frames of many
// shapes, gains and shift distances are streamed through the feed channel
// while a local predictor computes each expected result word. A checker
// compares every result word field by field, with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int   LINE_MAX = 2048;
    localparam int   SHIFT_MAX = 4;
    localparam int   SLOTS = 2 * SHIFT_MAX;
    localparam int   STALL_LIMIT = 3000;
    localparam int   ITEM_COUNT = 1850;
    localparam int   QUIET_TAIL = 1500;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            feed_valid = 1'b0;
    logic                            feed_ready;
    cssf_pkg::in_word_t              feed_word = '0;
    logic                            result_valid;
    logic                            result_ready = 1'b0;
    cssf_pkg::out_word_t             result_word;
    logic                            psel = 1'b0;
    logic                            penable = 1'b0;
    logic                            pwrite = 1'b0;
    logic [cssf_pkg::APB_ADDR_W-1:0] paddr = '0;
    logic [cssf_pkg::APB_DATA_W-1:0] pwdata = '0;
    logic [cssf_pkg::APB_DATA_W-1:0] prdata;
    logic                            pready;

    logic [11:0] cfg_width = cssf_pkg::WIDTH_RESET;
    logic [15:0] cfg_height = cssf_pkg::HEIGHT_RESET;
    logic [7:0]  cfg_gain = cssf_pkg::GAIN_RESET;
    logic [2:0]  cfg_shift = cssf_pkg::SHIFT_RESET;

    logic [7:0] line_mem [0:SLOTS*LINE_MAX-1];
    int         in_row = 0, in_col = 0, out_row = 0, out_col = 0;

    cssf_pkg::out_word_t expected_words[$];
    int         error_count = 0;
    int         words_fed = 0, words_checked = 0, clamp_count = 0, frame_count = 0;
    bit         idle_enable = 1'b1;
    int         stall_left = 0;
    int         quiet_cycles = 0;

    always #4 clk = ~clk;

    cross_shift_sharpen_filter dut (
        .clk(clk), .rst_n(rst_n),
        .feed_valid(feed_valid), .feed_ready(feed_ready), .feed_word(feed_word),
        .result_valid(result_valid), .result_ready(result_ready),
        .result_word(result_word),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    function automatic int eff_width();
        if (cfg_width == 0) return 1;
        return (cfg_width > LINE_MAX) ? LINE_MAX : int'(cfg_width);
    endfunction

    function automatic int eff_height();
        return (cfg_height == 0) ? 1 : int'(cfg_height);
    endfunction

    function automatic int eff_shift();
        if (cfg_shift == 0) return 1;
        return (cfg_shift > SHIFT_MAX) ? SHIFT_MAX : int'(cfg_shift);
    endfunction

    function automatic int slot(int r, int c);
        return (r % SLOTS) * LINE_MAX + (c % LINE_MAX);
    endfunction

    task automatic sharpen_pixel(int bottom, int wd, int ht, int sv);
        int                  p, vs, hs, half, num, den, q;
        cssf_pkg::out_word_t ow;
        p = line_mem[slot(out_row, out_col)];
        vs = 0;
        hs = 0;
        ow = '0;
        if (out_row >= sv && out_row + sv < ht)
            vs = line_mem[slot(out_row - sv, out_col)]
               + ((bottom >= 0) ? bottom : int'(line_mem[slot(out_row + sv, out_col)]));
        if (out_col >= sv && out_col + sv < wd)
            hs = line_mem[slot(out_row, out_col - sv)] + line_mem[slot(out_row, out_col + sv)];
        half = (vs + hs) / 2;
        num = 512 * p - int'(cfg_gain) * half;
        den = 2 * (256 - int'(cfg_gain));
        q = num / den;
        if (q < 0) begin
            q = 0;
            ow.clamped = 1'b1;
        end
        else if (q > 255) begin
            q = 255;
            ow.clamped = 1'b1;
        end
        if (out_col + 1 >= wd) begin
            out_col = 0;
            out_row++;
        end
        else
            out_col++;
        ow.pixel_out = q[7:0];
        ow.end_of_frame = (out_row >= ht);
        expected_words.push_back(ow);
    endtask

    task automatic predict_word(cssf_pkg::in_word_t w);
        int wd, ht, sv;
        wd = eff_width();
        ht = eff_height();
        sv = eff_shift();
        if (in_row >= ht && out_row >= ht) begin
            in_row = 0;
            in_col = 0;
            out_row = 0;
            out_col = 0;
        end
        if (in_row >= ht) begin
            if (out_row < ht)
                sharpen_pixel(-1, wd, ht, sv);
            return;
        end
        if (w.opcode == cssf_pkg::OP_FLUSH)
            return;
        if (out_row < ht && out_row + sv == in_row && out_col == in_col)
            sharpen_pixel(int'(w.pixel_in), wd, ht, sv);
        line_mem[slot(in_row, in_col)] = w.pixel_in;
        if (in_col + 1 >= wd) begin
            in_col = 0;
            in_row++;
        end
        else
            in_col++;
    endtask

    task automatic send_word(logic op, logic [7:0] pix);
        cssf_pkg::in_word_t w;
        w.opcode = op;
        w.pixel_in = pix;
        if (idle_enable && $urandom_range(0, 5) == 0) begin
            feed_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        feed_valid <= 1'b1;
        feed_word <= w;
        do
            @(posedge clk);
        while (!feed_ready);
        predict_word(w);
        words_fed++;
    endtask

    task automatic write_reg(logic [1:0] index, logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= cssf_pkg::APB_ADDR_W'({index, 2'b00});
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (index)
            cssf_pkg::REG_WIDTH:  cfg_width = value[11:0];
            cssf_pkg::REG_HEIGHT: cfg_height = value[15:0];
            cssf_pkg::REG_GAIN:   cfg_gain = value[7:0];
            cssf_pkg::REG_SHIFT:  cfg_shift = value[2:0];
            default:              cfg_shift = cfg_shift;
        endcase
    endtask

    task automatic wait_idle();
        feed_valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    function automatic logic [7:0] pick_pixel(int style);
        case (style)
            0:       return $urandom_range(0, 1) ? 8'd255 : 8'd0;
            1:       return 8'($urandom_range(120, 135));
            default: return 8'($urandom);
        endcase
    endfunction

    // One complete frame: the input rows, then drain words until the last
    // result is due. Flushes sprinkled into the input change nothing.
    task automatic run_frame(int w, int h, int k, int v, int style, int noise);
        wait_idle();
        write_reg(cssf_pkg::REG_WIDTH, w);
        write_reg(cssf_pkg::REG_HEIGHT, h);
        write_reg(cssf_pkg::REG_GAIN, k);
        write_reg(cssf_pkg::REG_SHIFT, v);
        do begin
            if (noise > 0 && $urandom_range(0, 99) < noise)
                send_word(cssf_pkg::OP_FLUSH, 8'($urandom));
            else
                send_word(cssf_pkg::OP_PIXEL, pick_pixel(style));
        end while (in_row < eff_height());
        while (out_row < eff_height()) begin
            if ($urandom_range(0, 7) == 0)
                send_word(cssf_pkg::OP_PIXEL, 8'($urandom));
            else
                send_word(cssf_pkg::OP_FLUSH, 8'($urandom));
        end
        frame_count++;
    endtask

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
        error_count++;
    endtask

    task automatic test_directed();
        run_frame(4, 3, 255, 1, 0, 20);
        run_frame(0, 0, 0, 0, 2, 0);
        run_frame(3, 2, 128, 7, 2, 10);
    endtask

    task automatic test_register_edges();
        run_frame(40, 1, 200, 5, 2, 0);
        run_frame(9, 9, 255, 4, 0, 5);
        run_frame(1, 12, 1, 3, 1, 5);
        run_frame(12, 1, 64, 2, 2, 0);
    endtask

    task automatic test_random_frames();
        int k;
        while (words_fed < ITEM_COUNT) begin
            if (words_fed > QUIET_TAIL)
                idle_enable = 1'b0;
            case ($urandom_range(0, 5))
                0:       k = 0;
                1:       k = 255;
                default: k = $urandom_range(0, 255);
            endcase
            run_frame($urandom_range(1, 24), $urandom_range(1, 10), k,
                      $urandom_range(0, 7), $urandom_range(0, 4), 5);
        end
    endtask

    always @(posedge clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            result_ready <= 1'b0;
        end
        else if (idle_enable && rst_n && $urandom_range(0, 9) == 0) begin
            stall_left <= $urandom_range(0, 10);
            result_ready <= 1'b0;
        end
        else
            result_ready <= 1'b1;
    end

    always @(posedge clk) begin
        cssf_pkg::out_word_t want;
        if (rst_n && result_valid && result_ready) begin
            if (expected_words.size() == 0)
                report_mismatch("unexpected word, pixel_out", result_word.pixel_out, -1);
            else begin
                want = expected_words.pop_front();
                if (result_word.pixel_out !== want.pixel_out)
                    report_mismatch("pixel_out", result_word.pixel_out, want.pixel_out);
                if (result_word.clamped !== want.clamped)
                    report_mismatch("clamped", result_word.clamped, want.clamped);
                if (result_word.end_of_frame !== want.end_of_frame)
                    report_mismatch("end_of_frame", result_word.end_of_frame,
                                    want.end_of_frame);
                if (want.clamped)
                    clamp_count++;
                words_checked++;
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (feed_valid && feed_ready) || (result_valid && result_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout with %0d words outstanding", expected_words.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_register_edges();
        test_random_frames();
        wait_idle();
        $display("covered %0d frames, %0d words fed, %0d result words checked",
                 frame_count, words_fed, words_checked);
        $display("%0d results saturated, %0d mismatches", clamp_count, error_count);
        if (error_count == 0 && expected_words.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/cssf_pkg.sv
hw/rtl/cssf_linebuf.sv
hw/rtl/cssf_div.sv
hw/rtl/cross_shift_sharpen_filter.sv
hw/rtl/cssf_checker.sv
bench/tb_top.sv
